// ===== src/lws_pkg.sv =====
// Shared types and constants of the lookahead slow weight synchronizer.
// Used by every module of the block but lws_ram; depends on nothing.
package lws_pkg;

    localparam int IDX_W    = 12;
    localparam int WEIGHT_W = 32;
    localparam int PERIOD_W = 16;
    localparam int RATIO_W  = 17;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 1;
    localparam int FRAC_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_RATIO   = 1'd1;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd5;
    localparam logic [RATIO_W-1:0]  RATIO_RESET  = 17'd32768;
    localparam logic [RATIO_W-1:0]  ALPHA_ONE    = 17'd65536;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic                       wr_init;
        logic                       do_sync;
        logic [IDX_W-1:0]           idx;
        logic signed [WEIGHT_W-1:0] w;
    } lws_item_t;

endpackage

// ===== src/lws_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Stand-alone; no package dependencies.
module lws_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/lws_front.sv =====
// Front end: accepts input beats, tracks the optimizer step phase and
// classifies each beat for the back end. Depends on lws_pkg.
module lws_front #(
    parameter int NUM_WEIGHTS = 4096
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_op,
    input  logic [lws_pkg::IDX_W-1:0]            s_weight_index,
    input  logic signed [lws_pkg::WEIGHT_W-1:0]  s_weight_value,
    input  logic                                 s_step_end,
    input  logic [lws_pkg::PERIOD_W-1:0]         sync_period,
    input  logic                                 q_ready,
    output logic                                 q_push,
    output lws_pkg::lws_item_t                   q_item
);
    import lws_pkg::*;

    logic [PERIOD_W-1:0] step_phase_reg;
    logic [PERIOD_W-1:0] step_phase_next;
    logic [PERIOD_W-1:0] period_eff;
    logic [PERIOD_W:0]   phase_inc;
    logic                sync_step;
    logic                in_range;
    logic                accept;

    assign s_ready    = q_ready;
    assign accept     = s_valid && s_ready;
    assign period_eff = (sync_period == '0) ? PERIOD_W'(1) : sync_period;
    assign phase_inc  = {1'b0, step_phase_reg} + (PERIOD_W + 1)'(1);
    assign sync_step  = phase_inc >= {1'b0, period_eff};
    assign in_range   = 32'(s_weight_index) < 32'(NUM_WEIGHTS);

    always_comb begin
        step_phase_next = step_phase_reg;
        if (accept && (s_op == OP_UPDATE) && s_step_end) begin
            step_phase_next = sync_step ? '0 : phase_inc[PERIOD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_phase_reg <= '0;
        end else begin
            step_phase_reg <= step_phase_next;
        end
    end

    assign q_push         = accept;
    assign q_item.wr_init = (s_op == OP_LOAD) && in_range;
    assign q_item.do_sync = (s_op == OP_UPDATE) && sync_step && in_range;
    assign q_item.idx     = s_weight_index;
    assign q_item.w       = s_weight_value;

endmodule

// ===== src/lws_queue.sv =====
// Short register queue that decouples the front end from the back end.
// Depends on lws_pkg for the item type and depth.
module lws_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  lws_pkg::lws_item_t push_item,
    output logic               in_ready,
    input  logic               pop,
    output logic               out_valid,
    output lws_pkg::lws_item_t out_item
);
    import lws_pkg::*;

    lws_item_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign in_ready  = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = slot_reg[rd_ptr_reg];
    assign do_push   = push && in_ready;
    assign do_pop    = pop && out_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/lws_back.sv =====
// Back end: reads the slow copy, interpolates toward the fast weight, writes
// the store and drives the result register. Depends on lws_pkg and lws_ram.
module lws_back #(
    parameter int NUM_WEIGHTS = 4096
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    input  lws_pkg::lws_item_t                   q_item,
    output logic                                 q_pop,
    input  logic [lws_pkg::RATIO_W-1:0]          alpha,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [lws_pkg::WEIGHT_W-1:0]  m_weight_out,
    output logic                                 m_synced
);
    import lws_pkg::*;

    localparam int AW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;

    lws_item_t                  rd_item_reg;
    logic                       rd_valid_reg;
    logic                       rd_valid_next;
    lws_item_t                  mx_item_reg;
    logic                       mx_valid_reg;
    logic                       mx_valid_next;
    logic signed [WEIGHT_W-1:0] mx_slow_reg;
    logic [WEIGHT_W-1:0]        mx_step_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [WEIGHT_W-1:0] out_weight_reg;
    logic                       out_synced_reg;
    logic                       lw_valid_reg;
    logic [IDX_W-1:0]           lw_idx_reg;
    logic [WEIGHT_W-1:0]        lw_data_reg;

    logic                       adv;
    logic                       mx_we;
    logic                       hazard;
    logic                       rd_move;
    logic [WEIGHT_W-1:0]        ram_rd_data;
    logic                       ram_wr_en;
    logic [WEIGHT_W-1:0]        ram_wr_data;
    logic [AW+IDX_W-1:0]        rd_idx_ext;
    logic [AW+IDX_W-1:0]        wr_idx_ext;
    logic signed [WEIGHT_W-1:0] slow_val;
    logic signed [WEIGHT_W:0]   diff;
    logic signed [RATIO_W:0]    alpha_s;
    logic signed [WEIGHT_W+RATIO_W+1:0] prod;
    logic [WEIGHT_W-1:0]        new_slow;

    assign adv     = !out_valid_reg || m_ready;
    assign mx_we   = mx_item_reg.wr_init || mx_item_reg.do_sync;
    assign hazard  = rd_valid_reg && mx_valid_reg && mx_we
                     && (mx_item_reg.idx == rd_item_reg.idx);
    assign rd_move = rd_valid_reg && adv && !hazard;
    assign q_pop   = q_valid && (!rd_valid_reg || rd_move);

    assign rd_idx_ext = {{AW{1'b0}}, q_item.idx};
    assign wr_idx_ext = {{AW{1'b0}}, mx_item_reg.idx};

    assign new_slow    = mx_slow_reg + mx_step_reg;
    assign ram_wr_en   = mx_valid_reg && adv && mx_we;
    assign ram_wr_data = mx_item_reg.do_sync ? new_slow : mx_item_reg.w;

    lws_ram #(
        .WIDTH  (WEIGHT_W),
        .DEPTH  (NUM_WEIGHTS),
        .ADDR_W (AW)
    ) u_slow_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_idx_ext[AW-1:0]),
        .wr_data (ram_wr_data),
        .rd_en   (q_pop),
        .rd_addr (rd_idx_ext[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    // The last store write may be newer than the registered read data.
    assign slow_val = (lw_valid_reg && (lw_idx_reg == rd_item_reg.idx))
                      ? lw_data_reg : ram_rd_data;
    assign diff     = {rd_item_reg.w[WEIGHT_W-1], rd_item_reg.w}
                      - {slow_val[WEIGHT_W-1], slow_val};
    assign alpha_s  = {1'b0, alpha};
    assign prod     = diff * alpha_s;

    always_comb begin
        rd_valid_next = rd_valid_reg;
        if (q_pop) begin
            rd_valid_next = 1'b1;
        end else if (rd_move) begin
            rd_valid_next = 1'b0;
        end
        mx_valid_next  = adv ? rd_move : mx_valid_reg;
        out_valid_next = adv ? mx_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            rd_item_reg <= q_item;
        end
        if (rd_move) begin
            mx_item_reg <= rd_item_reg;
            mx_slow_reg <= slow_val;
            mx_step_reg <= prod[WEIGHT_W+FRAC_W-1:FRAC_W];
        end
        if (adv && mx_valid_reg) begin
            out_weight_reg <= mx_item_reg.do_sync ? new_slow : mx_item_reg.w;
            out_synced_reg <= mx_item_reg.do_sync;
        end
        if (ram_wr_en) begin
            lw_idx_reg  <= mx_item_reg.idx;
            lw_data_reg <= ram_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg  <= 1'b0;
            mx_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            lw_valid_reg  <= 1'b0;
        end else begin
            rd_valid_reg  <= rd_valid_next;
            mx_valid_reg  <= mx_valid_next;
            out_valid_reg <= out_valid_next;
            lw_valid_reg  <= lw_valid_reg || ram_wr_en;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_weight_out = out_weight_reg;
    assign m_synced     = out_synced_reg;

endmodule

// ===== src/lookahead_slow_weight_sync.sv =====
// Top level of the lookahead slow weight synchronizer: configuration
// registers, front end, decoupling queue and back end. Depends on lws_pkg.
//
// Input beats (s_ channel) carry one weight element each: op 0 loads the slow
// copy, op 1 carries a fast weight after the inner optimizer step. Every
// input beat yields exactly one result beat on the m_ channel, in order.
// On a sync step an in-range update moves its slow copy toward the fast
// weight by mix_ratio and returns the new slow value with m_synced set.
// Results reach m_valid through the queue, the store read stage, the
// multiply stage and the output register. Throughput is one beat per cycle
// while the receiver takes results; two back-to-back beats that hit the same
// weight_index while the first one writes the store stall the second in the
// store read stage, held by the store's read-modify-write loop.
// When the receiver stalls, the back end holds and the four-entry queue
// absorbs further beats before s_ready drops.
// Reset clears the step phase and restores sync_period 5 and mix_ratio
// 0.5. The slow store is not cleared; entries must be loaded before use.
// Configuration writes take effect at once and belong to idle periods.
module lookahead_slow_weight_sync #(
    parameter int NUM_WEIGHTS = 4096
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [lws_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lws_pkg::CFG_W-1:0]            cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_op,
    input  logic [lws_pkg::IDX_W-1:0]            s_weight_index,
    input  logic signed [lws_pkg::WEIGHT_W-1:0]  s_weight_value,
    input  logic                                 s_step_end,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [lws_pkg::WEIGHT_W-1:0]  m_weight_out,
    output logic                                 m_synced
);
    import lws_pkg::*;

    logic [PERIOD_W-1:0] sync_period_reg;
    logic [PERIOD_W-1:0] sync_period_next;
    logic [RATIO_W-1:0]  mix_ratio_reg;
    logic [RATIO_W-1:0]  mix_ratio_next;
    logic [RATIO_W-1:0]  alpha_sat;

    logic      push;
    lws_item_t push_item;
    logic      queue_ready;
    logic      pop;
    logic      queue_valid;
    lws_item_t queue_item;

    always_comb begin
        sync_period_next = sync_period_reg;
        mix_ratio_next   = mix_ratio_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SYNC_PERIOD: begin
                    sync_period_next = cfg_wdata[PERIOD_W-1:0];
                end
                CFG_MIX_RATIO: begin
                    mix_ratio_next = cfg_wdata[RATIO_W-1:0];
                end
                default: begin
                    sync_period_next = sync_period_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_period_reg <= PERIOD_RESET;
            mix_ratio_reg   <= RATIO_RESET;
        end else begin
            sync_period_reg <= sync_period_next;
            mix_ratio_reg   <= mix_ratio_next;
        end
    end

    assign alpha_sat = (mix_ratio_reg > ALPHA_ONE) ? ALPHA_ONE : mix_ratio_reg;

    lws_front #(
        .NUM_WEIGHTS (NUM_WEIGHTS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_weight_index (s_weight_index),
        .s_weight_value (s_weight_value),
        .s_step_end     (s_step_end),
        .sync_period    (sync_period_reg),
        .q_ready        (queue_ready),
        .q_push         (push),
        .q_item         (push_item)
    );

    lws_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .in_ready  (queue_ready),
        .pop       (pop),
        .out_valid (queue_valid),
        .out_item  (queue_item)
    );

    lws_back #(
        .NUM_WEIGHTS (NUM_WEIGHTS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (queue_valid),
        .q_item       (queue_item),
        .q_pop        (pop),
        .alpha        (alpha_sat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_weight_out (m_weight_out),
        .m_synced     (m_synced)
    );

endmodule
